@@ design/ials_pkg.sv @@
`default_nettype none

package ials_pkg;

    localparam int CAPACITY = 128;
    localparam int DATA_W   = 32;
    localparam int POS_W    = 8;
    localparam int OUT_CNT_W = 8;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    // Common width for comparing positions, counts and cell indexes
    localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

    // Read tree: two registered OR levels of GRP inputs each
    localparam int GRP      = 16;
    localparam int L1_N     = (CAPACITY + GRP - 1) / GRP;
    localparam int L2_N     = (L1_N + GRP - 1) / GRP;

    localparam logic [2:0] OP_PUSH   = 3'd0;
    localparam logic [2:0] OP_INSERT = 3'd1;
    localparam logic [2:0] OP_REMOVE = 3'd2;
    localparam logic [2:0] OP_READ   = 3'd3;
    localparam logic [2:0] OP_SORT   = 3'd4;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_PUSH,
        CELL_INSERT,
        CELL_REMOVE,
        CELL_SORT
    } cell_mode_t;

    typedef struct packed {
        cell_mode_t         mode;
        logic [CMP_W-1:0]   pos;
        logic [CMP_W-1:0]   count;
        logic [DATA_W-1:0]  value;
        logic               phase;
    } cell_ctrl_t;

endpackage

`default_nettype wire

@@ design/ials_req_if.sv @@
`default_nettype none

interface ials_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  op;
    logic [7:0]  position;
    logic signed [31:0] item_value;

    modport source (output valid, output op, output position, output item_value, input ready);
    modport sink (input valid, input op, input position, input item_value, output ready);
endinterface

`default_nettype wire

@@ design/ials_rsp_if.sv @@
`default_nettype none

interface ials_rsp_if;
    logic        valid;
    logic        ready;
    logic signed [31:0] read_data;
    logic [7:0]  entry_count;
    logic [1:0]  status;

    modport source (output valid, output read_data, output entry_count, output status,
                    input ready);
    modport sink (input valid, input read_data, input entry_count, input status,
                  output ready);
endinterface

`default_nettype wire

@@ design/ials_cell.sv @@
`default_nettype none

module ials_cell (
    input  wire logic                           clk,
    input  wire ials_pkg::cell_ctrl_t           ctrl,
    input  wire logic [ials_pkg::CMP_W-1:0]     index,
    input  wire logic [ials_pkg::DATA_W-1:0]    left_value,
    input  wire logic [ials_pkg::DATA_W-1:0]    right_value,
    output logic [ials_pkg::DATA_W-1:0]         value
);

    logic [ials_pkg::DATA_W-1:0] value_reg;
    logic [ials_pkg::DATA_W-1:0] value_next;
    logic [ials_pkg::CMP_W-1:0]  index_up;

    assign index_up = index + ials_pkg::CMP_W'(1);

    always_comb
    begin
        value_next = value_reg;
        unique case (ctrl.mode)
            ials_pkg::CELL_PUSH:
            begin
                if (index == ctrl.count)
                    value_next = ctrl.value;
            end
            ials_pkg::CELL_INSERT:
            begin
                if (index == ctrl.pos)
                    value_next = ctrl.value;
                else if (index > ctrl.pos && index <= ctrl.count)
                    value_next = left_value;
            end
            ials_pkg::CELL_REMOVE:
            begin
                if (index >= ctrl.pos && index_up < ctrl.count)
                    value_next = right_value;
            end
            ials_pkg::CELL_SORT:
            begin
                // lower cell of a pair keeps the minimum, upper cell the maximum
                if (index[0] == ctrl.phase && index_up < ctrl.count)
                begin
                    if ($signed(right_value) < $signed(value_reg))
                        value_next = right_value;
                end
                else if (index[0] != ctrl.phase && index != '0 && index < ctrl.count)
                begin
                    if ($signed(value_reg) < $signed(left_value))
                        value_next = left_value;
                end
            end
            default:
            begin
                value_next = value_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;

endmodule

`default_nettype wire

@@ design/ials_read_tree.sv @@
`default_nettype none

module ials_read_tree (
    input  wire logic                           clk,
    input  wire logic [ials_pkg::DATA_W-1:0]    values [ials_pkg::CAPACITY],
    input  wire logic [ials_pkg::CMP_W-1:0]     pos,
    output logic [ials_pkg::DATA_W-1:0]         read_data
);

    logic [ials_pkg::DATA_W-1:0] l1_reg  [ials_pkg::L1_N];
    logic [ials_pkg::DATA_W-1:0] l1_next [ials_pkg::L1_N];
    logic [ials_pkg::DATA_W-1:0] l2_reg  [ials_pkg::L2_N];
    logic [ials_pkg::DATA_W-1:0] l2_next [ials_pkg::L2_N];

    // Mask each cell by its index match and OR groups together
    always_comb
    begin
        for (int g = 0; g < ials_pkg::L1_N; g++)
        begin
            l1_next[g] = '0;
            for (int k = 0; k < ials_pkg::GRP; k++)
            begin
                if (g * ials_pkg::GRP + k < ials_pkg::CAPACITY)
                begin
                    if (pos == ials_pkg::CMP_W'(g * ials_pkg::GRP + k))
                        l1_next[g] = l1_next[g] | values[g * ials_pkg::GRP + k];
                end
            end
        end
    end

    always_comb
    begin
        for (int g = 0; g < ials_pkg::L2_N; g++)
        begin
            l2_next[g] = '0;
            for (int k = 0; k < ials_pkg::GRP; k++)
            begin
                if (g * ials_pkg::GRP + k < ials_pkg::L1_N)
                    l2_next[g] = l2_next[g] | l1_reg[g * ials_pkg::GRP + k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        l1_reg <= l1_next;
        l2_reg <= l2_next;
    end

    always_comb
    begin
        read_data = '0;
        for (int g = 0; g < ials_pkg::L2_N; g++)
            read_data = read_data | l2_reg[g];
    end

endmodule

`default_nettype wire

@@ design/indexed_array_list_with_sort.sv @@
`default_nettype none

// Channel  Role   Payload
// -------  -----  ----------------------------------------
// req      sink   op, position, item_value
// rsp      source read_data, entry_count, status
//
// Push, insert, remove, read and unused ops go from accept to result through S_GATHER1
// and S_GATHER2 (the registered read tree), S_APPLY (cell row update) and S_FINISH
// (output register load); a new item is taken only in idle. Sort of two or more
// entries adds count odd-even passes. Reset clears count and control, not cells.
// A result waits in the output register while the next item is accepted; the
// block stalls in its final step until that register is free.

module indexed_array_list_with_sort (
    input  wire logic   clk,
    input  wire logic   rst_n,
    ials_req_if.sink    req,
    ials_rsp_if.source  rsp
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_GATHER1,
        S_GATHER2,
        S_APPLY,
        S_SORT,
        S_FINISH
    } state_t;

    localparam logic [ials_pkg::OUT_CNT_W-1:0] FULL_COUNT8 =
        ials_pkg::OUT_CNT_W'(ials_pkg::CAPACITY);

    state_t state_reg, state_next;

    logic [2:0]                    op_reg, op_next;
    logic [ials_pkg::CMP_W-1:0]    pos_reg, pos_next;
    logic [ials_pkg::DATA_W-1:0]   val_reg, val_next;
    logic [ials_pkg::CNT_W-1:0]    count_reg, count_next;
    logic [ials_pkg::CNT_W-1:0]    pass_reg, pass_next;
    logic [ials_pkg::DATA_W-1:0]   res_data_reg, res_data_next;
    logic [1:0]                    res_status_reg, res_status_next;

    logic                          rsp_valid_reg, rsp_valid_next;
    logic [ials_pkg::DATA_W-1:0]   rsp_data_reg, rsp_data_next;
    logic [ials_pkg::OUT_CNT_W-1:0] rsp_count_reg, rsp_count_next;
    logic [1:0]                    rsp_status_reg, rsp_status_next;

    ials_pkg::cell_ctrl_t          ctrl;
    logic [ials_pkg::DATA_W-1:0]   cell_value [ials_pkg::CAPACITY];
    logic [ials_pkg::DATA_W-1:0]   tree_data;
    logic [ials_pkg::CMP_W-1:0]    count_ext;
    logic                          full;

    assign count_ext = ials_pkg::CMP_W'(count_reg);
    assign full      = (count_reg == ials_pkg::CNT_W'(ials_pkg::CAPACITY));

    genvar i;
    generate
        for (i = 0; i < ials_pkg::CAPACITY; i++)
        begin : g_cell
            logic [ials_pkg::DATA_W-1:0] left_value;
            logic [ials_pkg::DATA_W-1:0] right_value;

            if (i == 0)
            begin : g_first
                assign left_value = '0;
            end
            else
            begin : g_inner_left
                assign left_value = cell_value[i-1];
            end

            if (i == ials_pkg::CAPACITY - 1)
            begin : g_last
                assign right_value = '0;
            end
            else
            begin : g_inner_right
                assign right_value = cell_value[i+1];
            end

            ials_cell u_cell (
                .clk         (clk),
                .ctrl        (ctrl),
                .index       (ials_pkg::CMP_W'(i)),
                .left_value  (left_value),
                .right_value (right_value),
                .value       (cell_value[i])
            );
        end
    endgenerate

    ials_read_tree u_read_tree (
        .clk       (clk),
        .values    (cell_value),
        .pos       (pos_reg),
        .read_data (tree_data)
    );

    assign req.ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        pos_next        = pos_reg;
        val_next        = val_reg;
        count_next      = count_reg;
        pass_next       = pass_reg;
        res_data_next   = res_data_reg;
        res_status_next = res_status_reg;
        rsp_valid_next  = rsp_valid_reg && !rsp.ready;
        rsp_data_next   = rsp_data_reg;
        rsp_count_next  = rsp_count_reg;
        rsp_status_next = rsp_status_reg;

        ctrl.mode  = ials_pkg::CELL_HOLD;
        ctrl.pos   = pos_reg;
        ctrl.count = count_ext;
        ctrl.value = val_reg;
        ctrl.phase = pass_reg[0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    op_next    = req.op;
                    pos_next   = ials_pkg::CMP_W'(req.position);
                    val_next   = req.item_value;
                    state_next = S_GATHER1;
                end
            end
            S_GATHER1:
            begin
                state_next = S_GATHER2;
            end
            S_GATHER2:
            begin
                state_next = S_APPLY;
            end
            S_APPLY:
            begin
                res_data_next   = '0;
                res_status_next = ials_pkg::ST_OK;
                state_next      = S_FINISH;
                unique case (op_reg)
                    ials_pkg::OP_PUSH:
                    begin
                        if (full)
                            res_status_next = ials_pkg::ST_FULL;
                        else
                        begin
                            ctrl.mode  = ials_pkg::CELL_PUSH;
                            count_next = count_reg + ials_pkg::CNT_W'(1);
                        end
                    end
                    ials_pkg::OP_INSERT:
                    begin
                        if (pos_reg > count_ext)
                            res_status_next = ials_pkg::ST_RANGE;
                        else if (full)
                            res_status_next = ials_pkg::ST_FULL;
                        else
                        begin
                            ctrl.mode  = ials_pkg::CELL_INSERT;
                            count_next = count_reg + ials_pkg::CNT_W'(1);
                        end
                    end
                    ials_pkg::OP_REMOVE:
                    begin
                        if (pos_reg >= count_ext)
                            res_status_next = ials_pkg::ST_RANGE;
                        else
                        begin
                            res_data_next = tree_data;
                            ctrl.mode     = ials_pkg::CELL_REMOVE;
                            count_next    = count_reg - ials_pkg::CNT_W'(1);
                        end
                    end
                    ials_pkg::OP_READ:
                    begin
                        if (pos_reg >= count_ext)
                            res_status_next = ials_pkg::ST_RANGE;
                        else
                            res_data_next = tree_data;
                    end
                    ials_pkg::OP_SORT:
                    begin
                        pass_next = '0;
                        if (count_reg >= ials_pkg::CNT_W'(2))
                            state_next = S_SORT;
                    end
                    default:
                    begin
                        res_status_next = ials_pkg::ST_OK;
                    end
                endcase
            end
            S_SORT:
            begin
                // one odd-even transposition pass per cycle, count passes in all
                ctrl.mode = ials_pkg::CELL_SORT;
                pass_next = pass_reg + ials_pkg::CNT_W'(1);
                if (pass_next >= count_reg)
                    state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_valid_next  = 1'b1;
                    rsp_data_next   = res_data_reg;
                    rsp_count_next  = count_ext[ials_pkg::OUT_CNT_W-1:0];
                    rsp_status_next = res_status_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            pass_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            pass_reg      <= pass_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        pos_reg        <= pos_next;
        val_reg        <= val_next;
        res_data_reg   <= res_data_next;
        res_status_reg <= res_status_next;
        rsp_data_reg   <= rsp_data_next;
        rsp_count_reg  <= rsp_count_next;
        rsp_status_reg <= rsp_status_next;
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.read_data   = rsp_data_reg;
    assign rsp.entry_count = rsp_count_reg;
    assign rsp.status      = rsp_status_reg;

    a_count_only_in_apply: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_APPLY) |=> $stable(count_reg))
        else $error("entry count changed outside the update step");

    a_full_means_capacity: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.status == ials_pkg::ST_FULL) |-> (rsp.entry_count == FULL_COUNT8))
        else $error("full status with list not at capacity");

    a_error_zero_data: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.status != ials_pkg::ST_OK) |-> (rsp.read_data == '0))
        else $error("error status with nonzero data");

    a_sort_needs_two: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SORT) |-> (count_reg >= ials_pkg::CNT_W'(2)))
        else $error("sort pass on a list shorter than two");

endmodule

`default_nettype wire

@@ bench/tb_indexed_array_list_with_sort.sv @@
`default_nettype none

module tb_indexed_array_list_with_sort;

    localparam int HALF_PERIOD  = 6;
    localparam int RESET_CYCLES = 12;
    localparam int RANDOM_ITEMS = 625;
    localparam int GROW_ITEMS   = 300;
    localparam int SHRINK_ITEMS = 120;
    localparam int QUIET_ITEMS  = 130;
    localparam int DRAIN_CYCLES = 20;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int LONG_HOLD    = 300;
    localparam int HOLD_TRIGGER = 40;
    localparam int N_DIRECTED   = 25;

    // Op codes the block leaves unused
    localparam logic [2:0] OP_SPARE_A = 3'd5;
    localparam logic [2:0] OP_SPARE_B = 3'd6;
    localparam logic [2:0] OP_SPARE_C = 3'd7;

    typedef enum {
        PH_GROW,
        PH_SHRINK,
        PH_MIX
    } mix_phase_t;

    typedef struct packed {
        logic signed [31:0] data;
        logic [7:0]         cnt;
        logic [1:0]         status;
    } list_result_t;

    typedef struct packed {
        logic [2:0]   op;
        logic [7:0]   pos;
        logic [31:0]  value;
        logic         typed;
        list_result_t want;
    } directed_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    always #HALF_PERIOD clk = ~clk;

    ials_req_if req_ch ();
    ials_rsp_if rsp_ch ();

    indexed_array_list_with_sort i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Mirror of the list contents
    logic signed [31:0] list_mirror [$];

    list_result_t pending_results [$];
    list_result_t exp_res;
    int           fail_count   = 0;
    int           results_seen = 0;
    int           items_sent   = 0;
    int           cycle_count  = 0;
    bit           idle_on      = 1'b1;
    bit           hold_active  = 1'b0;

    directed_row_t directed_rows [N_DIRECTED] = '{
        '{ials_pkg::OP_READ,   8'd0,   32'd0,          1'b1,
          '{32'd0,          8'd0, ials_pkg::ST_RANGE}},
        '{ials_pkg::OP_REMOVE, 8'd0,   32'd0,          1'b1,
          '{32'd0,          8'd0, ials_pkg::ST_RANGE}},
        '{ials_pkg::OP_SORT,   8'd0,   32'd0,          1'b1,
          '{32'd0,          8'd0, ials_pkg::ST_OK}},
        '{ials_pkg::OP_PUSH,   8'd0,   32'h7FFF_FFFF,  1'b1,
          '{32'd0,          8'd1, ials_pkg::ST_OK}},
        '{ials_pkg::OP_SORT,   8'd0,   32'd0,          1'b1,
          '{32'd0,          8'd1, ials_pkg::ST_OK}},
        '{ials_pkg::OP_PUSH,   8'd255, 32'h8000_0000,  1'b1,
          '{32'd0,          8'd2, ials_pkg::ST_OK}},
        '{ials_pkg::OP_INSERT, 8'd3,   32'd1,          1'b1,
          '{32'd0,          8'd2, ials_pkg::ST_RANGE}},
        '{ials_pkg::OP_INSERT, 8'd0,   32'hFFFF_FFFF,  1'b1,
          '{32'd0,          8'd3, ials_pkg::ST_OK}},
        '{ials_pkg::OP_INSERT, 8'd3,   32'd0,          1'b1,
          '{32'd0,          8'd4, ials_pkg::ST_OK}},
        '{ials_pkg::OP_READ,   8'd0,   32'd0,          1'b1,
          '{32'hFFFF_FFFF,  8'd4, ials_pkg::ST_OK}},
        '{ials_pkg::OP_READ,   8'd3,   32'd0,          1'b1,
          '{32'd0,          8'd4, ials_pkg::ST_OK}},
        '{ials_pkg::OP_READ,   8'd4,   32'd0,          1'b1,
          '{32'd0,          8'd4, ials_pkg::ST_RANGE}},
        '{OP_SPARE_A,          8'd0,   32'hFFFF_FFFF,  1'b1,
          '{32'd0,          8'd4, ials_pkg::ST_OK}},
        '{OP_SPARE_B,          8'd1,   32'd0,          1'b1,
          '{32'd0,          8'd4, ials_pkg::ST_OK}},
        '{OP_SPARE_C,          8'd2,   32'h8000_0000,  1'b1,
          '{32'd0,          8'd4, ials_pkg::ST_OK}},
        '{ials_pkg::OP_SORT,   8'd0,   32'd0,          1'b1,
          '{32'd0,          8'd4, ials_pkg::ST_OK}},
        '{ials_pkg::OP_READ,   8'd0,   32'd0,          1'b1,
          '{32'h8000_0000,  8'd4, ials_pkg::ST_OK}},
        '{ials_pkg::OP_READ,   8'd3,   32'd0,          1'b1,
          '{32'h7FFF_FFFF,  8'd4, ials_pkg::ST_OK}},
        '{ials_pkg::OP_REMOVE, 8'd1,   32'd0,          1'b1,
          '{32'hFFFF_FFFF,  8'd3, ials_pkg::ST_OK}},
        '{ials_pkg::OP_REMOVE, 8'd2,   32'd0,          1'b1,
          '{32'h7FFF_FFFF,  8'd2, ials_pkg::ST_OK}},
        '{ials_pkg::OP_READ,   8'd128, 32'd0,          1'b1,
          '{32'd0,          8'd2, ials_pkg::ST_RANGE}},
        '{ials_pkg::OP_INSERT, 8'd128, 32'd1,          1'b1,
          '{32'd0,          8'd2, ials_pkg::ST_RANGE}},
        '{ials_pkg::OP_REMOVE, 8'd0,   32'd0,          1'b1,
          '{32'h8000_0000,  8'd1, ials_pkg::ST_OK}},
        '{ials_pkg::OP_REMOVE, 8'd0,   32'd0,          1'b1,
          '{32'd0,          8'd0, ials_pkg::ST_OK}},
        '{ials_pkg::OP_INSERT, 8'd0,   32'h1234_5678,  1'b0,
          '{32'd0,          8'd0, ials_pkg::ST_OK}}
    };

    function automatic list_result_t apply_list_request(input logic [2:0] op,
                                                        input logic [7:0] pos,
                                                        input logic signed [31:0] value);
        list_result_t       res;
        int                 p;
        int                 n;
        int                 k;
        int                 j;
        logic signed [31:0] key;
        res.data   = '0;
        res.status = ials_pkg::ST_OK;
        p = int'(pos);
        n = list_mirror.size();
        case (op)
            ials_pkg::OP_PUSH:
                if (n >= ials_pkg::CAPACITY)
                    res.status = ials_pkg::ST_FULL;
                else
                    list_mirror.push_back(value);
            ials_pkg::OP_INSERT:
                if (p > n)
                    res.status = ials_pkg::ST_RANGE;
                else if (n >= ials_pkg::CAPACITY)
                    res.status = ials_pkg::ST_FULL;
                else
                    list_mirror.insert(p, value);
            ials_pkg::OP_REMOVE:
                if (p >= n)
                    res.status = ials_pkg::ST_RANGE;
                else
                begin
                    res.data = list_mirror[p];
                    list_mirror.delete(p);
                end
            ials_pkg::OP_READ:
                if (p >= n)
                    res.status = ials_pkg::ST_RANGE;
                else
                    res.data = list_mirror[p];
            ials_pkg::OP_SORT:
                for (k = 1; k < n; k++)
                begin
                    key = list_mirror[k];
                    j = k;
                    while (j > 0 && key < list_mirror[j - 1])
                    begin
                        list_mirror[j] = list_mirror[j - 1];
                        j--;
                    end
                    list_mirror[j] = key;
                end
            default: ;
        endcase
        res.cnt = 8'(list_mirror.size());
        return res;
    endfunction

    function automatic logic [2:0] pick_op(input mix_phase_t ph);
        int r;
        r = $urandom_range(0, 99);
        if (r == 0)
            return OP_SPARE_A;
        if (r == 1)
            return OP_SPARE_B;
        if (r == 2)
            return OP_SPARE_C;
        case (ph)
            PH_GROW:
                if (r < 45) return ials_pkg::OP_PUSH;
                else if (r < 72) return ials_pkg::OP_INSERT;
                else if (r < 82) return ials_pkg::OP_REMOVE;
                else if (r < 95) return ials_pkg::OP_READ;
                else return ials_pkg::OP_SORT;
            PH_SHRINK:
                if (r < 10) return ials_pkg::OP_PUSH;
                else if (r < 18) return ials_pkg::OP_INSERT;
                else if (r < 85) return ials_pkg::OP_REMOVE;
                else if (r < 95) return ials_pkg::OP_READ;
                else return ials_pkg::OP_SORT;
            default:
                if (r < 28) return ials_pkg::OP_PUSH;
                else if (r < 50) return ials_pkg::OP_INSERT;
                else if (r < 72) return ials_pkg::OP_REMOVE;
                else if (r < 92) return ials_pkg::OP_READ;
                else return ials_pkg::OP_SORT;
        endcase
    endfunction

    // Mostly valid indexes, with some beyond the end
    function automatic logic [7:0] pick_position(input logic [2:0] op);
        int n;
        int r;
        n = list_mirror.size();
        r = $urandom_range(0, 99);
        if (r < 12)
            return 8'($urandom_range(0, 255));
        if (op == ials_pkg::OP_INSERT)
            return 8'($urandom_range(0, n));
        if (n == 0)
            return 8'd0;
        return 8'($urandom_range(0, n - 1));
    endfunction

    // Extremes and small values that repeat, besides plain random words
    function automatic logic [31:0] pick_value();
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'hFFFF_FFFF;
            3: return 32'($urandom_range(0, 7));
            default: return $urandom;
        endcase
    endfunction

    // Offer one item from a falling edge and hold it until accepted
    task automatic send_item(input logic [2:0] op, input logic [7:0] pos,
                             input logic [31:0] value, input bit typed,
                             input list_result_t want, input bit allow_idle);
        list_result_t predicted;
        if (allow_idle && $urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 11)) @(negedge clk);
        req_ch.valid      = 1'b1;
        req_ch.op         = op;
        req_ch.position   = pos;
        req_ch.item_value = value;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        predicted = apply_list_request(op, pos, value);
        pending_results.push_back(typed ? want : predicted);
        items_sent++;
        @(negedge clk);
        req_ch.valid      = 1'b0;
        req_ch.op         = 3'($urandom);
        req_ch.position   = 8'($urandom);
        req_ch.item_value = $urandom;
    endtask

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $error("cycle limit of %0d reached", CYCLE_LIMIT);
            $display("tb_indexed_array_list_with_sort NOT OK");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            results_seen++;
            if (pending_results.size() == 0)
            begin
                $error("unexpected result: read_data %0d", rsp_ch.read_data);
                fail_count++;
            end
            else
            begin
                exp_res = pending_results.pop_front();
                if (rsp_ch.read_data !== exp_res.data)
                begin
                    $error("read_data: expected %0d, got %0d", exp_res.data, rsp_ch.read_data);
                    fail_count++;
                end
                if (rsp_ch.entry_count !== exp_res.cnt)
                begin
                    $error("entry_count: expected %0d, got %0d", exp_res.cnt,
                           rsp_ch.entry_count);
                    fail_count++;
                end
                if (rsp_ch.status !== exp_res.status)
                begin
                    $error("status: expected %0d, got %0d", exp_res.status, rsp_ch.status);
                    fail_count++;
                end
            end
        end
    end

    // Long stall of the receiver once traffic is under way
    initial
    begin : hold_proc
        wait (results_seen >= HOLD_TRIGGER);
        @(negedge clk);
        hold_active = 1'b1;
        repeat (LONG_HOLD) @(negedge clk);
        hold_active = 1'b0;
    end

    initial
    begin : sink_proc
        int idle_left;
        idle_left = 0;
        rsp_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (idle_left == 0 && idle_on && $urandom_range(0, 4) == 0)
                idle_left = $urandom_range(1, 11);
            if (idle_left > 0)
            begin
                rsp_ch.ready = 1'b0;
                idle_left--;
            end
            else
                rsp_ch.ready = !hold_active;
        end
    end

    initial
    begin : main_proc
        logic [2:0]  op;
        logic [7:0]  pos;
        logic [31:0] value;
        mix_phase_t  ph;
        req_ch.valid      = 1'b0;
        req_ch.op         = '0;
        req_ch.position   = '0;
        req_ch.item_value = '0;
        rst_n = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        if (rsp_ch.valid !== 1'b0)
        begin
            $error("rsp valid after reset: expected 0, got %b", rsp_ch.valid);
            fail_count++;
        end
        if (req_ch.ready !== 1'b1)
        begin
            $error("req ready after reset: expected 1, got %b", req_ch.ready);
            fail_count++;
        end

        for (int n = 0; n < N_DIRECTED; n++)
            send_item(directed_rows[n].op, directed_rows[n].pos, directed_rows[n].value,
                      directed_rows[n].typed, directed_rows[n].want, 1'b1);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n < GROW_ITEMS)
                ph = PH_GROW;
            else if (n < GROW_ITEMS + SHRINK_ITEMS)
                ph = PH_SHRINK;
            else
                ph = PH_MIX;
            if (n == RANDOM_ITEMS - QUIET_ITEMS)
                idle_on = 1'b0;
            op    = pick_op(ph);
            pos   = pick_position(op);
            value = pick_value();
            send_item(op, pos, value, 1'b0, '0, idle_on);
        end

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0 && pending_results.size() == 0 && results_seen == items_sent)
            $display("tb_indexed_array_list_with_sort OK");
        else
            $display("tb_indexed_array_list_with_sort NOT OK");
        $finish;
    end

endmodule

`default_nettype wire

@@ indexed_array_list_with_sort.f @@
design/ials_pkg.sv
design/ials_req_if.sv
design/ials_rsp_if.sv
design/ials_cell.sv
design/ials_read_tree.sv
design/indexed_array_list_with_sort.sv
bench/tb_indexed_array_list_with_sort.sv
